// ===== sv/fdt_pkg.sv =====
// Package with shared constants and types of the flow tracker.
package fdt_pkg;
	localparam int SlotCountDef = 65535;
	localparam int TopSlotsDef = 6;
	localparam int PeriodW = 17;

	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_PERIOD = 2'd1;
	localparam logic [1:0] MODE_REPORT = 2'd2;

	localparam logic [1:0] KIND_RECORD = 2'd0;
	localparam logic [1:0] KIND_TOP = 2'd1;
	localparam logic [1:0] KIND_PERIOD = 2'd2;

	localparam logic [1:0] REG_SRC_MATCH = 2'd0;
	localparam logic [1:0] REG_SRC_MASK = 2'd1;
	localparam logic [1:0] REG_DST_MATCH = 2'd2;
	localparam logic [1:0] REG_DST_MASK = 2'd3;

	typedef struct packed {
		logic [7:0] proto;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [63:0] dpk;
		logic [63:0] dby;
	} top_entry_t;
endpackage

// ===== sv/fdt_hash.sv =====
// Iterative slot hash: steps of h = (h*31 + v) mod SLOT_COUNT, each in a quotient phase and a subtract phase.
module fdt_hash #(
	parameter int SLOT_COUNT = fdt_pkg::SlotCountDef
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [31:0] saddr,
	input logic [31:0] daddr,
	input logic [15:0] sport,
	input logic [15:0] dport,
	output logic done,
	output logic [15:0] hash
);
	import fdt_pkg::*;

	localparam int NW = 23;
	localparam int LW = $clog2(SLOT_COUNT);
	// Rounded-up reciprocal; the quotient estimate is exact for every 23-bit dividend.
	localparam logic [24:0] RECIP = 25'(((64'd1 << (NW + LW)) + 64'(SLOT_COUNT) - 64'd1)
		/ 64'(SLOT_COUNT));

	logic [3:0] step_q;
	logic run_q;
	logic ph_q;
	logic [15:0] h_q;
	logic [22:0] r1_q;
	logic [22:0] q_q;
	logic [15:0] v;
	logic [21:0] prod;
	logic [22:0] r1;
	logic [47:0] qprod;
	logic [22:0] q_d;
	logic [22:0] r2;
	logic [15:0] nxt;

	always_comb begin
		case (step_q)
			4'd0: v = {8'd0, saddr[31:24]};
			4'd1: v = {8'd0, saddr[23:16]};
			4'd2: v = {8'd0, saddr[15:8]};
			4'd3: v = {8'd0, saddr[7:0]};
			4'd4: v = {8'd0, daddr[31:24]};
			4'd5: v = {8'd0, daddr[23:16]};
			4'd6: v = {8'd0, daddr[15:8]};
			4'd7: v = {8'd0, daddr[7:0]};
			4'd8: v = sport;
			default: v = dport;
		endcase
		// The first phase forms h*31 + v and its quotient, the second subtracts the multiple.
		prod = 22'({h_q, 5'd0}) - 22'(h_q);
		r1 = 23'(prod) + 23'(v);
		qprod = 48'(r1) * 48'(RECIP);
		q_d = 23'(qprod >> (NW + LW));
		r2 = r1_q - q_q * 23'(SLOT_COUNT);
		nxt = r2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q <= 1'b0;
			ph_q <= 1'b0;
			h_q <= '0;
			r1_q <= '0;
			q_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				ph_q <= 1'b0;
				step_q <= '0;
				h_q <= '0;
			end else if (run_q) begin
				if (!ph_q) begin
					r1_q <= r1;
					q_q <= q_d;
					ph_q <= 1'b1;
				end else begin
					h_q <= nxt;
					ph_q <= 1'b0;
					step_q <= step_q + 4'd1;
					if (step_q == 4'd9) begin
						run_q <= 1'b0;
						done <= 1'b1;
					end
				end
			end
		end
	end

	assign hash = h_q;
endmodule

// ===== sv/flow_delta_top_tracker.sv =====
// Top level of the flow delta tracker: filter, slot memory update and sorted top list.
//  channel | handshake         | payload
//  input   | start / busy      | mode, proto, addresses, ports, totals
//  result  | strobe            | kind .. last
//  config  | cfg_valid/ready   | cfg_index, cfg_data
// A passing record runs the hash (S_HASH), latches the slot into addr_q, reads the slot
// memory (S_READ) and shows its result word from the update (S_UPD); the next word is taken
// back in S_IDLE. A rejected record or a period event gives its word on the next cycle and
// busy stays low. A report gives TOP_SLOTS-1 words, one per cycle.
// After reset the slot memory is cleared one entry a cycle, busy high.
// The receiver cannot stall; at most one result leaves per cycle.
module flow_delta_top_tracker #(
	parameter int SLOT_COUNT = fdt_pkg::SlotCountDef,
	parameter int TOP_SLOTS = fdt_pkg::TopSlotsDef
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] mode,
	input logic [7:0] proto,
	input logic [31:0] src_addr,
	input logic [31:0] dst_addr,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic [63:0] pkt_total,
	input logic [63:0] byte_total,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic strobe,
	output logic [1:0] kind,
	output logic accepted,
	output logic [15:0] slot,
	output logic [7:0] out_proto,
	output logic [31:0] out_src_addr,
	output logic [31:0] out_dst_addr,
	output logic [15:0] out_src_port,
	output logic [15:0] out_dst_port,
	output logic [63:0] delta_packets,
	output logic [63:0] delta_bytes,
	output logic last
);
	import fdt_pkg::*;

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int TW = $clog2(TOP_SLOTS);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_READ, S_UPD, S_REPORT} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [31:0] src_match_q, src_mask_q, dst_match_q, dst_mask_q;
	top_entry_t cur_q;
	logic [63:0] pk_q, by_q;
	logic [AW-1:0] addr_q;
	logic [TW-1:0] rep_q;
	logic [PeriodW-1:0] period_q;
	top_entry_t top_q [TOP_SLOTS];

	logic [127:0] mem [SLOT_COUNT];
	logic [127:0] rd_s1;

	logic hgo, hdone;
	logic [15:0] hval;
	logic pass;

	fdt_hash #(.SLOT_COUNT(SLOT_COUNT)) u_hash (
		.clk(clk), .arst_n(arst_n), .go(hgo),
		.saddr(cur_q.saddr), .daddr(cur_q.daddr),
		.sport(cur_q.sport), .dport(cur_q.dport),
		.done(hdone), .hash(hval)
	);

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign hgo = (state_q == S_IDLE) && start && (mode == MODE_RECORD) && pass;
	assign pass = ((src_match_q == '0) || ((src_addr & src_mask_q) == (src_match_q & src_mask_q)))
		&& ((dst_match_q == '0) || ((dst_addr & dst_mask_q) == (dst_match_q & dst_mask_q)));

	// New entry and the insertion result.
	top_entry_t ne;
	top_entry_t ins [TOP_SLOTS];
	top_entry_t rest [TOP_SLOTS];
	logic [TW-1:0] pos;
	logic [TW:0] p;

	always_comb begin
		ne = cur_q;
		ne.dpk = pk_q - rd_s1[127:64];
		ne.dby = by_q - rd_s1[63:0];
		pos = (period_q < PeriodW'(TOP_SLOTS - 1)) ? TW'(period_q) : TW'(TOP_SLOTS - 1);
		for (int i = 0; i < TOP_SLOTS; i++) begin
			rest[i] = (TW'(i) < pos) ? top_q[i] : ((i + 1 < TOP_SLOTS) ? top_q[i + 1] : top_q[i]);
		end
		p = '0;
		for (int i = 0; i < TOP_SLOTS - 1; i++) begin
			if (rest[i].dpk >= ne.dpk) p = (TW + 1)'(i + 1);
		end
		for (int i = 0; i < TOP_SLOTS; i++) begin
			if ((TW + 1)'(i) < p) ins[i] = rest[i];
			else if ((TW + 1)'(i) == p) ins[i] = ne;
			else ins[i] = rest[(i > 0) ? i - 1 : 0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) mem[clr_q] <= '0;
		else if (state_q == S_UPD) mem[addr_q] <= {pk_q, by_q};
		rd_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			src_match_q <= '0;
			src_mask_q <= '0;
			dst_match_q <= '0;
			dst_mask_q <= '0;
			period_q <= '0;
			rep_q <= '0;
			cur_q <= '0;
			pk_q <= '0;
			by_q <= '0;
			addr_q <= '0;
			strobe <= 1'b0;
			kind <= KIND_RECORD;
			accepted <= 1'b0;
			slot <= '0;
			out_proto <= '0;
			out_src_addr <= '0;
			out_dst_addr <= '0;
			out_src_port <= '0;
			out_dst_port <= '0;
			delta_packets <= '0;
			delta_bytes <= '0;
			last <= 1'b0;
			for (int i = 0; i < TOP_SLOTS; i++) top_q[i] <= '0;
		end else begin
			strobe <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SRC_MATCH: src_match_q <= cfg_data;
					REG_SRC_MASK: src_mask_q <= cfg_data;
					REG_DST_MATCH: dst_match_q <= cfg_data;
					REG_DST_MASK: dst_mask_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SLOT_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						cur_q.proto <= proto;
						cur_q.saddr <= src_addr;
						cur_q.daddr <= dst_addr;
						cur_q.sport <= src_port;
						cur_q.dport <= dst_port;
						cur_q.dpk <= '0;
						cur_q.dby <= '0;
						pk_q <= pkt_total;
						by_q <= byte_total;
						kind <= KIND_RECORD;
						accepted <= 1'b0;
						slot <= '0;
						out_proto <= proto;
						out_src_addr <= src_addr;
						out_dst_addr <= dst_addr;
						out_src_port <= src_port;
						out_dst_port <= dst_port;
						delta_packets <= '0;
						delta_bytes <= '0;
						last <= 1'b1;
						unique case (mode)
							MODE_RECORD: begin
								if (pass) state_q <= S_HASH;
								else strobe <= 1'b1;
							end
							MODE_PERIOD: begin
								for (int i = 0; i < TOP_SLOTS; i++) begin
									top_q[i].dpk <= '0;
									top_q[i].dby <= '0;
								end
								period_q <= '0;
								kind <= KIND_PERIOD;
								out_proto <= '0;
								out_src_addr <= '0;
								out_dst_addr <= '0;
								out_src_port <= '0;
								out_dst_port <= '0;
								strobe <= 1'b1;
							end
							MODE_REPORT: begin
								rep_q <= '0;
								state_q <= S_REPORT;
							end
							default: ;
						endcase
					end
				end
				S_HASH: begin
					if (hdone) begin
						addr_q <= AW'(hval);
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_UPD;
				S_UPD: begin
					for (int i = 0; i < TOP_SLOTS; i++) top_q[i] <= ins[i];
					if (period_q != '1) period_q <= period_q + PeriodW'(1);
					accepted <= 1'b1;
					slot <= 16'(addr_q);
					delta_packets <= ne.dpk;
					delta_bytes <= ne.dby;
					strobe <= 1'b1;
					state_q <= S_IDLE;
				end
				S_REPORT: begin
					kind <= KIND_TOP;
					accepted <= 1'b0;
					slot <= '0;
					out_proto <= top_q[rep_q].proto;
					out_src_addr <= top_q[rep_q].saddr;
					out_dst_addr <= top_q[rep_q].daddr;
					out_src_port <= top_q[rep_q].sport;
					out_dst_port <= top_q[rep_q].dport;
					delta_packets <= top_q[rep_q].dpk;
					delta_bytes <= top_q[rep_q].dby;
					last <= (rep_q == TW'(TOP_SLOTS - 2));
					strobe <= 1'b1;
					rep_q <= rep_q + TW'(1);
					if (rep_q == TW'(TOP_SLOTS - 2)) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A memory update only happens after a completed read of the same slot.
	a_upd_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> $past(state_q) == S_READ) else $error("update without read");
	// After an update the first two top list entries are in order by delta packets.
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == S_UPD && state_q == S_IDLE |-> top_q[0].dpk >= top_q[1].dpk)
		else $error("top list out of order");
	// Report words carry the top kind.
	a_report_kind: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == S_REPORT |-> strobe && kind == KIND_TOP) else $error("bad report word");
endmodule

// ===== dv/tb_flow_delta_top_tracker.sv =====
// Testbench for the flow delta tracker: directed and random records, periods and reports.
module tb_flow_delta_top_tracker;
	import fdt_pkg::*;

	localparam int SlotN = 65535;
	localparam int TopN = 6;
	localparam int DrainCycles = 40;
	localparam int WatchLimit = 200000;
	localparam logic [1:0] MODE_IGNORED = 2'd3;

	typedef struct {
		logic [1:0] kind;
		logic accepted;
		logic [15:0] slot;
		top_entry_t flow;
		logic last;
	} flow_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = MODE_RECORD;
	logic [7:0] proto = '0;
	logic [31:0] src_addr = '0;
	logic [31:0] dst_addr = '0;
	logic [15:0] src_port = '0;
	logic [15:0] dst_port = '0;
	logic [63:0] pkt_total = '0;
	logic [63:0] byte_total = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_SRC_MATCH;
	logic [31:0] cfg_data = '0;
	logic strobe;
	logic [1:0] kind;
	logic accepted;
	logic [15:0] slot;
	logic [7:0] out_proto;
	logic [31:0] out_src_addr;
	logic [31:0] out_dst_addr;
	logic [15:0] out_src_port;
	logic [15:0] out_dst_port;
	logic [63:0] delta_packets;
	logic [63:0] delta_bytes;
	logic last;

	flow_delta_top_tracker dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow state of the tracker.
	logic [31:0] sm_match, sm_mask, dm_match, dm_mask;
	logic [63:0] slot_pkts [int];
	logic [63:0] slot_bytes [int];
	top_entry_t top_flows [TopN];
	int unsigned flows_in_period;
	flow_result_t pending_results [$];
	int errors = 0;
	int idle_watch = 0;
	int burst_left = 0;

	// Flow pool so that slots are revisited and deltas are meaningful.
	top_entry_t flow_pool [16];

	function automatic int flow_slot(input top_entry_t f);
		int unsigned h;
		h = 0;
		for (int i = 3; i >= 0; i--) h = (h * 31 + ((f.saddr >> (8 * i)) & 32'hFF)) % SlotN;
		for (int i = 3; i >= 0; i--) h = (h * 31 + ((f.daddr >> (8 * i)) & 32'hFF)) % SlotN;
		h = (h * 31 + 32'(f.sport)) % SlotN;
		h = (h * 31 + 32'(f.dport)) % SlotN;
		return h;
	endfunction

	task automatic rank_flow(input top_entry_t nf);
		top_entry_t others [$];
		int drop;
		int p;
		drop = (flows_in_period < TopN - 1) ? flows_in_period : TopN - 1;
		for (int i = 0; i < TopN; i++) if (i != drop) others.push_back(top_flows[i]);
		p = 0;
		while (p < others.size() && others[p].dpk >= nf.dpk) p++;
		others.insert(p, nf);
		for (int i = 0; i < TopN; i++) top_flows[i] = others[i];
	endtask

	// Works out the results of one accepted word; dpk/dby carry the cumulative totals.
	task automatic predict_word(input logic [1:0] m, input top_entry_t f);
		flow_result_t r;
		int h;
		logic pass;
		r.kind = KIND_RECORD;
		r.accepted = 1'b0;
		r.slot = '0;
		r.flow = '0;
		r.last = 1'b1;
		if (m == MODE_RECORD) begin
			r.flow = f;
			r.flow.dpk = '0;
			r.flow.dby = '0;
			pass = (sm_match == 0 || (f.saddr & sm_mask) == (sm_match & sm_mask)) &&
				(dm_match == 0 || (f.daddr & dm_mask) == (dm_match & dm_mask));
			if (pass) begin
				h = flow_slot(f);
				if (!slot_pkts.exists(h)) begin
					slot_pkts[h] = '0;
					slot_bytes[h] = '0;
				end
				r.flow.dpk = f.dpk - slot_pkts[h];
				r.flow.dby = f.dby - slot_bytes[h];
				slot_pkts[h] = f.dpk;
				slot_bytes[h] = f.dby;
				rank_flow(r.flow);
				if (flows_in_period < 17'h1FFFF) flows_in_period++;
				r.accepted = 1'b1;
				r.slot = h[15:0];
			end
			pending_results.push_back(r);
		end else if (m == MODE_PERIOD) begin
			for (int i = 0; i < TopN; i++) begin
				top_flows[i].dpk = '0;
				top_flows[i].dby = '0;
			end
			flows_in_period = 0;
			r.kind = KIND_PERIOD;
			pending_results.push_back(r);
		end else if (m == MODE_REPORT) begin
			for (int i = 0; i < TopN - 1; i++) begin
				r.kind = KIND_TOP;
				r.flow = top_flows[i];
				r.last = (i == TopN - 2);
				pending_results.push_back(r);
			end
		end
	endtask

	// Sends one word and keeps the sender in bursts with random gaps.
	task automatic send_word(input logic [1:0] m, input top_entry_t f);
		start <= 1'b1;
		mode <= m;
		proto <= f.proto;
		src_addr <= f.saddr;
		dst_addr <= f.daddr;
		src_port <= f.sport;
		dst_port <= f.dport;
		pkt_total <= f.dpk;
		byte_total <= f.dby;
		do @(posedge clk); while (busy);
		predict_word(m, f);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SRC_MATCH: sm_match = val;
			REG_SRC_MASK: sm_mask = val;
			REG_DST_MATCH: dm_match = val;
			default: dm_mask = val;
		endcase
	endtask

	task automatic set_filter(input logic [31:0] sm, smk, dm, dmk);
		drain();
		write_reg(REG_SRC_MATCH, sm);
		write_reg(REG_SRC_MASK, smk);
		write_reg(REG_DST_MATCH, dm);
		write_reg(REG_DST_MASK, dmk);
		cfg_valid <= 1'b0;
	endtask

	function automatic top_entry_t make_flow(input logic [7:0] p, input logic [31:0] sa, da,
			input logic [15:0] sp, dp, input logic [63:0] pk, by);
		top_entry_t f;
		f.proto = p;
		f.saddr = sa;
		f.daddr = da;
		f.sport = sp;
		f.dport = dp;
		f.dpk = pk;
		f.dby = by;
		return f;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_record_extremes;
		send_word(MODE_RECORD, make_flow(8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 64'h0, 64'h0));
		send_word(MODE_RECORD, make_flow(8'hFF, '1, '1, '1, '1, '1, '1));
		// Totals below the stored ones wrap the deltas.
		send_word(MODE_RECORD, make_flow(8'hFF, '1, '1, '1, '1, 64'h5, 64'h7));
		send_word(MODE_RECORD, make_flow(8'h06, 32'h0A000001, 32'hC0A80001, 16'd80, 16'd443,
			64'd100, 64'd64000));
		// The unused mode is ignored and gives no result.
		send_word(MODE_IGNORED, make_flow(8'h11, 32'h1, 32'h2, 16'd3, 16'd4, 64'd5, 64'd6));
		send_word(MODE_REPORT, '0);
	endtask

	task automatic test_list_ranking;
		send_word(MODE_PERIOD, '0);
		// Equal deltas must land after the older entries; more than six records overflow.
		for (int i = 0; i < 9; i++)
			send_word(MODE_RECORD, make_flow(8'd17, 32'(32'h0B000000 + i), 32'h0C000000, 16'd53,
				16'(1000 + i), (i % 3 == 0) ? 64'd500 : 64'd100 * 64'(i), 64'(1000 + i)));
		send_word(MODE_REPORT, '0);
		send_word(MODE_PERIOD, '0);
		send_word(MODE_REPORT, '0);
	endtask

	task automatic test_filters;
		set_filter(32'h0A000000, 32'hFF000000, 32'h0, 32'h0);
		send_word(MODE_RECORD, make_flow(8'd6, 32'h0A123456, 32'h1, 16'd1, 16'd2, 64'd9, 64'd9));
		send_word(MODE_RECORD, make_flow(8'd6, 32'h0B123456, 32'h1, 16'd1, 16'd2, 64'd9, 64'd9));
		set_filter(32'h0, 32'h0, '1, '1);
		send_word(MODE_RECORD, make_flow(8'd6, 32'h5, '1, 16'd1, 16'd2, 64'd9, 64'd9));
		send_word(MODE_RECORD, make_flow(8'd6, 32'h5, 32'hFFFFFFFE, 16'd1, 16'd2, 64'd9, 64'd9));
		set_filter('1, 32'h0, 32'h1, 32'h0);
		send_word(MODE_RECORD, make_flow(8'd1, 32'h7, 32'h8, 16'd1, 16'd2, 64'd3, 64'd3));
		send_word(MODE_REPORT, '0);
		set_filter(32'h0, 32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_random_traffic;
		int pick;
		top_entry_t f;
		for (int i = 0; i < 16; i++)
			flow_pool[i] = make_flow(8'($urandom()), $urandom(), $urandom(), 16'($urandom()),
				16'($urandom()), '0, '0);
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 1)
				set_filter(flow_pool[0].saddr, 32'hFFFF0000, 32'h0, $urandom());
			else if (phase == 2)
				set_filter(32'h0, $urandom(), flow_pool[1].daddr, 32'hFF000000);
			else if (phase == 3)
				set_filter(flow_pool[2].saddr, 32'hF0000000, flow_pool[2].daddr, 32'hF0000000);
			for (int n = 0; n < 75; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 72) begin
					if ($urandom_range(0, 7) == 0) begin
						f = make_flow(8'($urandom()), $urandom(), $urandom(), 16'($urandom()),
							16'($urandom()), rand64(), rand64());
					end else begin
						f = flow_pool[$urandom_range(0, 15)];
						f.dpk = f.dpk + 64'($urandom_range(0, 3000));
						f.dby = f.dby + 64'($urandom_range(0, 900000));
						if ($urandom_range(0, 15) == 0) f.dpk = rand64();
						for (int k = 0; k < 16; k++)
							if (flow_pool[k].saddr == f.saddr && flow_pool[k].sport == f.sport)
								flow_pool[k] = f;
					end
					send_word(MODE_RECORD, f);
				end else if (pick < 82) begin
					send_word(MODE_PERIOD, '0);
				end else if (pick < 96) begin
					send_word(MODE_REPORT, '0);
				end else begin
					send_word(MODE_IGNORED, make_flow(8'($urandom()), $urandom(), $urandom(),
						16'($urandom()), 16'($urandom()), rand64(), rand64()));
				end
			end
		end
		set_filter('1, '1, '1, '1);
		for (int n = 0; n < 6; n++)
			send_word(MODE_RECORD, make_flow(8'($urandom()), $urandom(), $urandom(),
				16'($urandom()), 16'($urandom()), rand64(), rand64()));
		send_word(MODE_REPORT, '0);
	endtask

	// Checks every result word against the oldest expectation.
	always @(posedge clk) begin
		flow_result_t e;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$error("result word with no expectation waiting");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (kind !== e.kind) begin
					$error("kind: expected %0d, actual %0d", e.kind, kind);
					errors++;
				end
				if (accepted !== e.accepted) begin
					$error("accepted: expected %0d, actual %0d", e.accepted, accepted);
					errors++;
				end
				if (slot !== e.slot) begin
					$error("slot: expected %0d, actual %0d", e.slot, slot);
					errors++;
				end
				if (out_proto !== e.flow.proto) begin
					$error("out_proto: expected %0h, actual %0h", e.flow.proto, out_proto);
					errors++;
				end
				if (out_src_addr !== e.flow.saddr) begin
					$error("out_src_addr: expected %0h, actual %0h", e.flow.saddr, out_src_addr);
					errors++;
				end
				if (out_dst_addr !== e.flow.daddr) begin
					$error("out_dst_addr: expected %0h, actual %0h", e.flow.daddr, out_dst_addr);
					errors++;
				end
				if (out_src_port !== e.flow.sport) begin
					$error("out_src_port: expected %0h, actual %0h", e.flow.sport, out_src_port);
					errors++;
				end
				if (out_dst_port !== e.flow.dport) begin
					$error("out_dst_port: expected %0h, actual %0h", e.flow.dport, out_dst_port);
					errors++;
				end
				if (delta_packets !== e.flow.dpk) begin
					$error("delta_packets: expected %0h, actual %0h", e.flow.dpk, delta_packets);
					errors++;
				end
				if (delta_bytes !== e.flow.dby) begin
					$error("delta_bytes: expected %0h, actual %0h", e.flow.dby, delta_bytes);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, actual %0d", e.last, last);
					errors++;
				end
			end
		end
	end

	// Watchdog; the slot memory clear after reset keeps busy high for a full memory pass.
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) idle_watch <= 0;
		else idle_watch <= idle_watch + 1;
		if (idle_watch >= WatchLimit) begin
			$display("flow_delta_top_tracker test failed");
			$finish;
		end
	end

	initial begin
		sm_match = '0;
		sm_mask = '0;
		dm_match = '0;
		dm_mask = '0;
		flows_in_period = 0;
		for (int i = 0; i < TopN; i++) top_flows[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_filter(32'h0, 32'h0, 32'h0, 32'h0);
		test_record_extremes();
		test_list_ranking();
		test_filters();
		test_random_traffic();
		drain();
		if (errors == 0) begin
			$display("flow_delta_top_tracker test passed");
		end else begin
			$display("flow_delta_top_tracker test failed");
		end
		$finish;
	end
endmodule

// ===== flow_delta_top_tracker.f =====
sv/fdt_pkg.sv
sv/fdt_hash.sv
sv/flow_delta_top_tracker.sv
dv/tb_flow_delta_top_tracker.sv
